[rtl/der_tlv_header_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// DER TLV header parser - assertion macros
// Shared concurrent assertion forms; the user module supplies clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef DER_TLV_HEADER_PARSER_TOP_MACROS_SVH
`define DER_TLV_HEADER_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTLV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dtlv_pkg.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - package
// Result codes, configuration register indexes and the result beat type.
// ----------------------------------------------------------------------------
package dtlv_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_AVAILABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COPY_EN         = 2'd1;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_OFFSET     = 3'd1;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
	localparam logic [2:0] ERR_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ERR_OVERRUN    = 3'd4;

	// Length byte: long-form flag and count field
	localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;
	localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

	typedef logic [1:0]  kind_t;
	typedef logic [7:0]  byte_t;
	typedef logic [63:0] length_t;
	typedef logic [3:0]  hsize_t;
	typedef logic [2:0]  errcode_t;

	typedef struct packed {
		logic     valid;
		kind_t    kind;
		byte_t    tag_byte;
		length_t  value_length;
		hsize_t   header_size;
		errcode_t error_code;
		byte_t    value_out;
		logic     last_value;
	} dtlv_res_t;

endpackage

[rtl/dtlv_byte_if.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - byte channel
// Valid/ready channel carrying one encoded byte per beat.
// ----------------------------------------------------------------------------
interface dtlv_byte_if;
	logic            valid;
	logic            ready;
	dtlv_pkg::byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/dtlv_result_if.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - result channel
// Valid/ready channel carrying one header, value byte or error per beat.
// ----------------------------------------------------------------------------
interface dtlv_result_if;
	logic               valid;
	logic               ready;
	dtlv_pkg::kind_t    kind;
	dtlv_pkg::byte_t    tag_byte;
	dtlv_pkg::length_t  value_length;
	dtlv_pkg::hsize_t   header_size;
	dtlv_pkg::errcode_t error_code;
	dtlv_pkg::byte_t    value_out;
	logic               last_value;

	modport source (output valid, output kind, output tag_byte, output value_length,
		output header_size, output error_code, output value_out, output last_value,
		input ready);
	modport sink (input valid, input kind, input tag_byte, input value_length,
		input header_size, input error_code, input value_out, input last_value,
		output ready);
endinterface

[rtl/dtlv_parser.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - parse state
// Per-byte tag/length/value state registers, budget counter and next-state logic.
// ----------------------------------------------------------------------------
module dtlv_parser #(
	parameter int MAX_LENGTH_BYTES = 8,
	parameter int COUNT_WIDTH      = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  dtlv_pkg::byte_t                    data_byte,
	input  logic                               cfg_wr_en,
	input  logic [dtlv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtlv_pkg::CFG_DATA_W-1:0]    cfg_data,
	output dtlv_pkg::dtlv_res_t                res
);
	import dtlv_pkg::*;

	`include "der_tlv_header_parser_top_macros.svh"

	localparam int LEN_W = 8 * MAX_LENGTH_BYTES;
	localparam int CMP_W = (LEN_W > COUNT_WIDTH) ? LEN_W : COUNT_WIDTH;

	localparam logic [2:0] PH_TAG   = 3'd0;
	localparam logic [2:0] PH_LEN   = 3'd1;
	localparam logic [2:0] PH_LONG  = 3'd2;
	localparam logic [2:0] PH_VALUE = 3'd3;
	localparam logic [2:0] PH_HALT  = 3'd4;

	logic [2:0]             phase_q, phase_n;
	logic [COUNT_WIDTH-1:0] remain_q, remain_n, rem_dec;
	logic [LEN_W-1:0]       len_acc_q, len_acc_n;
	logic [3:0]             len_left_q, len_left_n;
	byte_t                  tag_q, tag_n;
	hsize_t                 hdr_cnt_q, hdr_cnt_n;
	logic [LEN_W-1:0]       val_left_q, val_left_n, val_dec;
	logic                   copy_q;

	logic                   do_fin;
	logic [LEN_W-1:0]       fin_len;
	logic [COUNT_WIDTH-1:0] fin_rem;
	hsize_t                 fin_hdr;
	logic [6:0]             long_cnt;

	always_comb begin
		phase_n    = phase_q;
		remain_n   = remain_q;
		len_acc_n  = len_acc_q;
		len_left_n = len_left_q;
		tag_n      = tag_q;
		hdr_cnt_n  = hdr_cnt_q;
		val_left_n = val_left_q;
		res        = '0;
		do_fin     = 1'b0;
		fin_len    = len_acc_q;
		fin_rem    = remain_q;
		fin_hdr    = hdr_cnt_q;
		long_cnt   = data_byte[6:0] & LEN_COUNT_MASK[6:0];
		rem_dec    = (remain_q != '0) ? remain_q - 1'b1 : '0;
		val_dec    = (val_left_q != '0) ? val_left_q - 1'b1 : '0;

		case (phase_q)
			PH_TAG: begin
				hdr_cnt_n  = '0;
				len_acc_n  = '0;
				len_left_n = '0;
				if (remain_q == '0) begin
					phase_n          = PH_HALT;
					res.valid        = 1'b1;
					res.kind         = KIND_ERROR;
					res.error_code   = ERR_OFFSET;
				end else begin
					tag_n     = data_byte;
					hdr_cnt_n = 4'd1;
					remain_n  = rem_dec;
					if (rem_dec == '0) begin
						phase_n         = PH_HALT;
						res.valid       = 1'b1;
						res.kind        = KIND_ERROR;
						res.tag_byte    = data_byte;
						res.header_size = 4'd1;
						res.error_code  = ERR_INCOMPLETE;
					end else begin
						phase_n = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				if (remain_q == '0) begin
					phase_n         = PH_HALT;
					res.valid       = 1'b1;
					res.kind        = KIND_ERROR;
					res.tag_byte    = tag_q;
					res.header_size = hdr_cnt_q;
					res.error_code  = ERR_INCOMPLETE;
				end else begin
					remain_n  = rem_dec;
					hdr_cnt_n = 4'd2;
					if ((data_byte & LEN_LONG_FLAG) != '0) begin
						if (long_cnt == '0 || long_cnt > 7'(MAX_LENGTH_BYTES)
								|| COUNT_WIDTH'(long_cnt) > rem_dec) begin
							phase_n         = PH_HALT;
							res.valid       = 1'b1;
							res.kind        = KIND_ERROR;
							res.tag_byte    = tag_q;
							res.header_size = 4'd2;
							res.error_code  = ERR_BAD_LENGTH;
						end else begin
							len_acc_n  = '0;
							len_left_n = long_cnt[3:0];
							phase_n    = PH_LONG;
						end
					end else begin
						len_acc_n = LEN_W'(data_byte);
						do_fin    = 1'b1;
						fin_len   = LEN_W'(data_byte);
						fin_rem   = rem_dec;
						fin_hdr   = 4'd2;
					end
				end
			end
			PH_LONG: begin
				if (remain_q == '0) begin
					phase_n         = PH_HALT;
					res.valid       = 1'b1;
					res.kind        = KIND_ERROR;
					res.tag_byte    = tag_q;
					res.header_size = hdr_cnt_q;
					res.error_code  = ERR_BAD_LENGTH;
				end else begin
					remain_n   = rem_dec;
					len_acc_n  = LEN_W'({len_acc_q, data_byte});
					hdr_cnt_n  = hdr_cnt_q + 4'd1;
					len_left_n = len_left_q - 4'd1;
					if (len_left_n == '0) begin
						do_fin  = 1'b1;
						fin_len = len_acc_n;
						fin_rem = rem_dec;
						fin_hdr = hdr_cnt_n;
					end
				end
			end
			PH_VALUE: begin
				remain_n         = rem_dec;
				val_left_n       = val_dec;
				res.valid        = 1'b1;
				res.kind         = KIND_VALUE;
				res.tag_byte     = tag_q;
				res.value_length = 64'(len_acc_q);
				res.header_size  = hdr_cnt_q;
				res.value_out    = data_byte;
				res.last_value   = (val_dec == '0);
				if (val_dec == '0) begin
					phase_n = PH_TAG;
				end
			end
			default: begin
				// halted: drop every byte
			end
		endcase

		// Length complete: check it against the budget, then emit the header
		if (do_fin) begin
			res.valid        = 1'b1;
			res.tag_byte     = tag_q;
			res.value_length = 64'(fin_len);
			res.header_size  = fin_hdr;
			if (CMP_W'(fin_len) > CMP_W'(fin_rem)) begin
				phase_n        = PH_HALT;
				res.kind       = KIND_ERROR;
				res.error_code = ERR_OVERRUN;
			end else begin
				val_left_n = fin_len;
				phase_n    = (copy_q && fin_len != '0) ? PH_VALUE : PH_TAG;
				res.kind   = KIND_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			remain_q   <= '0;
			len_acc_q  <= '0;
			len_left_q <= '0;
			tag_q      <= '0;
			hdr_cnt_q  <= '0;
			val_left_q <= '0;
			copy_q     <= 1'b1;
		end else begin
			if (fire) begin
				phase_q    <= phase_n;
				remain_q   <= remain_n;
				len_acc_q  <= len_acc_n;
				len_left_q <= len_left_n;
				tag_q      <= tag_n;
				hdr_cnt_q  <= hdr_cnt_n;
				val_left_q <= val_left_n;
			end
			if (cfg_wr_en && cfg_index == CFG_BYTES_AVAILABLE) begin
				remain_q <= COUNT_WIDTH'(cfg_data);
			end
			if (cfg_wr_en && cfg_index == CFG_COPY_EN) begin
				copy_q <= cfg_data[0];
			end
		end
	end

	`DTLV_ASSERT_NEXT(a_halt_sticky, phase_q == PH_HALT, phase_q == PH_HALT,
		"parser left the halt state")
	`DTLV_ASSERT_NEXT(a_error_halts, fire && res.valid && res.kind == KIND_ERROR,
		phase_q == PH_HALT, "error beat did not halt the parser")
	`DTLV_ASSERT_SAME(a_value_left, phase_q == PH_VALUE, val_left_q != '0,
		"value phase with no value bytes left")
	`DTLV_ASSERT_SAME(a_long_count, phase_q == PH_LONG,
		len_left_q != '0 && len_left_q <= 4'(MAX_LENGTH_BYTES),
		"long-form byte count out of range")

endmodule

[rtl/dtlv_out_stage.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - result register
// Holds one result beat and frees the byte side whenever the slot can take one.
// ----------------------------------------------------------------------------
module dtlv_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  dtlv_pkg::dtlv_res_t   res,
	output logic                  load,
	dtlv_result_if.source         result_ch
);
	import dtlv_pkg::*;

	logic      valid_s1;
	dtlv_res_t data_s1;

	assign load = !valid_s1 || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && fire) begin
			data_s1 <= res;
		end
	end

	assign result_ch.valid        = valid_s1;
	assign result_ch.kind         = data_s1.kind;
	assign result_ch.tag_byte     = data_s1.tag_byte;
	assign result_ch.value_length = data_s1.value_length;
	assign result_ch.header_size  = data_s1.header_size;
	assign result_ch.error_code   = data_s1.error_code;
	assign result_ch.value_out    = data_s1.value_out;
	assign result_ch.last_value   = data_s1.last_value;

endmodule

[rtl/der_tlv_header_parser_top.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - top level
// Decodes ASN.1 DER tag/length headers from a byte stream and passes values on.
// ----------------------------------------------------------------------------
//
//  channel     dir  beat content
//  ---------   ---  -----------------------------------------------------------
//  byte_ch     in   data_byte: one byte of the encoded buffer
//  result_ch   out  kind, tag_byte, value_length, header_size, error_code,
//                   value_out, last_value
//  cfg_*       in   plain write: bytes_available (index 0), copy enable (index 1)
//
//  One byte per clock while the result slot is free or being emptied. Each
//  accepted byte updates the parse state in a single registered pass; its
//  result, if any, sits in the result register the cycle after.
//  Reset (arst_n low) returns to tag parsing with an empty budget and copy on.
//  A stalled result holds the result register and drops byte_ch.ready; bytes
//  that give no result still need a free result slot.
//
module der_tlv_header_parser_top #(
	parameter int MAX_LENGTH_BYTES = 8,
	parameter int COUNT_WIDTH      = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	dtlv_byte_if.sink                          byte_ch,
	dtlv_result_if.source                      result_ch,
	input  logic                               cfg_wr_en,
	input  logic [dtlv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtlv_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dtlv_pkg::*;

	logic      load;
	logic      fire;
	dtlv_res_t res;

	// Take a byte whenever the result slot is free or being emptied
	assign byte_ch.ready = load;
	assign fire          = byte_ch.valid && load;

	// Parse state: tag, length form, long-length bytes, value bytes, halt
	dtlv_parser #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
		.COUNT_WIDTH      (COUNT_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_ch.data_byte),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	// Result register between the parse logic and the result channel
	dtlv_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.load      (load),
		.result_ch (result_ch)
	);

endmodule

[verif/der_tlv_header_parser_top_test.sv]
// ----------------------------------------------------------------------------
// DER TLV header parser - block-level test
// Feeds DER byte streams on the byte channel under random flow control, keeps
// a cycle-free model of the tag/length decoder in step with every accepted
// beat, and checks each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module der_tlv_header_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtlv_pkg::*;

	localparam int MAX_LENGTH_BYTES   = 8;
	localparam int COUNT_WIDTH        = 32;
	localparam int RANDOM_ITEMS       = 900;
	localparam int IDLE_SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT     = 5000;

	// Register indexes past the end of the map; writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

	typedef enum logic [2:0] {PH_TAG, PH_LEN, PH_LONG, PH_VALUE, PH_HALT} parse_phase_t;

	// Ways of driving the decoder into its error halt; one is picked per run,
	// since only reset leaves the halt
	typedef enum int {
		FAULT_EMPTY_BUDGET,
		FAULT_TAG_IS_LAST,
		FAULT_LEN_STARVED,
		FAULT_COUNT_ZERO,
		FAULT_COUNT_TOO_BIG,
		FAULT_COUNT_OVER_BUDGET,
		FAULT_LONG_STARVED,
		FAULT_SHORT_OVERRUN,
		FAULT_LONG_OVERRUN
	} fault_case_t;

	typedef struct packed {
		kind_t    kind;
		byte_t    tag_byte;
		length_t  value_length;
		hsize_t   header_size;
		errcode_t error_code;
		byte_t    value_out;
		logic     last_value;
	} result_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dtlv_byte_if   byte_ch();
	dtlv_result_if result_ch();

	der_tlv_header_parser_top #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder model: register copies and parse state, as after reset
	// ------------------------------------------------------------------
	logic [COUNT_WIDTH-1:0] budget_left = '0;
	logic                   copy_on = 1'b1;
	parse_phase_t           parse_phase = PH_TAG;
	length_t                len_acc = '0;
	logic [3:0]             len_bytes_left = '0;
	byte_t                  cur_tag = '0;
	hsize_t                 hdr_count = '0;
	length_t                value_left = '0;

	result_beat_t tlv_beats_due[$];
	byte_t        plan_bytes[$];
	int unsigned  bad_beats = 0;

	int unsigned src_steady_left = 0;
	int unsigned sink_hold_left = 0;
	int unsigned sink_stall_left = 0;
	int unsigned sink_steady_left = 0;
	int unsigned quiet_cycles = 0;

	// Hold-off requests from the tests; the sink serves each one once
	int unsigned hold_requests = 0;
	int unsigned holds_taken = 0;

	function automatic void spend_budget();
		if (budget_left != 0)
			budget_left--;
	endfunction

	// Latch the halt and build the error beat; header_size is what was consumed
	function automatic result_beat_t halt_with(errcode_t code, byte_t tag, length_t len);
		parse_phase = PH_HALT;
		return '{KIND_ERROR, tag, len, hdr_count, code, 8'h00, 1'b0};
	endfunction

	// Length is complete: either it overruns the budget or the header goes out
	function automatic result_beat_t close_header();
		if (len_acc > length_t'(budget_left))
			return halt_with(ERR_OVERRUN, cur_tag, len_acc);
		value_left = len_acc;
		// copy enable is sampled here, not when the tag arrived
		parse_phase = (copy_on && len_acc != 0) ? PH_VALUE : PH_TAG;
		return '{KIND_HEADER, cur_tag, len_acc, hdr_count, ERR_NONE, 8'h00, 1'b0};
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] index,
		logic [CFG_DATA_W-1:0] value);
		case (index)
			CFG_BYTES_AVAILABLE: budget_left = value[COUNT_WIDTH-1:0];
			CFG_COPY_EN:         copy_on = value[0];
			default: ;
		endcase
	endfunction

	// Advance the model by one accepted byte; returns 1 when a result beat is due
	function automatic bit decode_byte(input byte_t b, output result_beat_t r);
		byte_t count;
		r = '0;
		case (parse_phase)
			PH_TAG: begin
				hdr_count = '0;
				len_acc = '0;
				len_bytes_left = '0;
				if (budget_left == 0) begin
					r = halt_with(ERR_OFFSET, 8'h00, '0);
					return 1'b1;
				end
				cur_tag = b;
				hdr_count = 4'd1;
				spend_budget();
				if (budget_left == 0) begin
					r = halt_with(ERR_INCOMPLETE, cur_tag, '0);
					return 1'b1;
				end
				parse_phase = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				if (budget_left == 0) begin
					r = halt_with(ERR_INCOMPLETE, cur_tag, '0);
					return 1'b1;
				end
				spend_budget();
				hdr_count = 4'd2;
				if ((b & LEN_LONG_FLAG) != 0) begin
					count = b & LEN_COUNT_MASK;
					if (count == 0 || count > MAX_LENGTH_BYTES || count > budget_left) begin
						r = halt_with(ERR_BAD_LENGTH, cur_tag, '0);
						return 1'b1;
					end
					len_acc = '0;
					len_bytes_left = count[3:0];
					parse_phase = PH_LONG;
					return 1'b0;
				end
				len_acc = length_t'(b);
				r = close_header();
				return 1'b1;
			end
			PH_LONG: begin
				if (budget_left == 0) begin
					r = halt_with(ERR_BAD_LENGTH, cur_tag, '0);
					return 1'b1;
				end
				spend_budget();
				len_acc = {len_acc[55:0], b};
				hdr_count++;
				len_bytes_left--;
				if (len_bytes_left != 0)
					return 1'b0;
				r = close_header();
				return 1'b1;
			end
			PH_VALUE: begin
				// budget saturates at zero here; value bytes still pass
				spend_budget();
				if (value_left != 0)
					value_left--;
				r = '{KIND_VALUE, cur_tag, len_acc, hdr_count, ERR_NONE, b, value_left == 0};
				if (value_left == 0)
					parse_phase = PH_TAG;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: check delivered beats, then step the model on new input
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			bad_beats++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : tlv_scoreboard
		result_beat_t want, got, fresh;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = '{result_ch.kind, result_ch.tag_byte, result_ch.value_length,
					result_ch.header_size, result_ch.error_code, result_ch.value_out,
					result_ch.last_value};
				if (tlv_beats_due.size() == 0) begin
					bad_beats++;
					$display("%0t ns: result beat expected none, got %p", $time, got);
				end else begin
					want = tlv_beats_due.pop_front();
					check_field("kind", 64'(want.kind), 64'(got.kind));
					check_field("tag_byte", 64'(want.tag_byte), 64'(got.tag_byte));
					check_field("value_length", want.value_length, got.value_length);
					check_field("header_size", 64'(want.header_size), 64'(got.header_size));
					check_field("error_code", 64'(want.error_code), 64'(got.error_code));
					check_field("value_out", 64'(want.value_out), 64'(got.value_out));
					check_field("last_value", 64'(want.last_value), 64'(got.last_value));
				end
			end
			// Writes and input beats never share an edge: writes wait for idle
			if (cfg_wr_en)
				apply_reg_write(cfg_index, cfg_data);
			if (byte_ch.valid && byte_ch.ready) begin
				if (decode_byte(byte_ch.data_byte, fresh))
					tlv_beats_due = {tlv_beats_due, fresh};
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any beat or register write counts as progress
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (byte_ch.valid && byte_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("der_tlv_header_parser_top: mismatch");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Result sink: random stalls, gap-free stretches, and on request one long
	// hold-off counted here so the block backs up onto the byte channel
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : result_sink
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (holds_taken != hold_requests) begin
			holds_taken = hold_requests;
			sink_hold_left = HOLD_OFF_CYCLES - 1;
			result_ch.ready <= 1'b0;
		end else if (sink_hold_left != 0) begin
			result_ch.ready <= 1'b0;
			sink_hold_left--;
		end else if (sink_stall_left != 0) begin
			result_ch.ready <= 1'b0;
			sink_stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			if (sink_steady_left != 0)
				sink_steady_left--;
			else if ($urandom_range(0, 99) < 3)
				sink_steady_left = $urandom_range(30, 100);
			else
				sink_stall_left = pick_gap();
		end
	end

	// ------------------------------------------------------------------
	// Byte source and register port
	// ------------------------------------------------------------------
	// Offer one beat and hold it until the block takes it; valid stays high
	// into the next call unless that call opens a gap
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		if (src_steady_left != 0) begin
			gap = 0;
			src_steady_left--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 99) < 3)
				src_steady_left = $urandom_range(30, 100);
		end
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_plan();
		while (plan_bytes.size() != 0)
			send_byte(plan_bytes.pop_front());
	endtask

	// Drop valid, drain every due beat, then let a byte that gives no result settle
	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (tlv_beats_due.size() != 0);
		repeat (IDLE_SETTLE_CYCLES) @(posedge clk);
	endtask

	// The trailing edge keeps back-to-back writes from stacking two drives in a step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Only bit 0 matters; toss the rest so every data bit moves
	task automatic set_copy(input bit on);
		write_reg(CFG_COPY_EN, ($urandom & ~32'h1) | CFG_DATA_W'(on));
	endtask

	// Append one byte to the planned stream
	function automatic void plan_add(input byte_t b);
		plan_bytes = {plan_bytes, b};
	endfunction

	// Queue one element: random tag, short or long form (long form padded with
	// leading zero bytes at random), and the content bytes when they will pass
	function automatic void plan_element(input bit with_value, input length_t len);
		int unsigned need, n, i;
		plan_add(byte_t'($urandom));
		need = 1;
		while (need < MAX_LENGTH_BYTES && (len >> (8 * need)) != 0)
			need++;
		if (len < 128 && $urandom_range(0, 3) != 0) begin
			plan_add(byte_t'(len));
		end else begin
			n = $urandom_range(need, MAX_LENGTH_BYTES);
			plan_add(LEN_LONG_FLAG | byte_t'(n));
			for (i = n; i > 0; i--)
				plan_add(byte_t'(len >> (8 * (i - 1))));
		end
		if (with_value)
			repeat (len) plan_add(byte_t'($urandom));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Short form with the budget sized exactly; a zero length with copy on
	// goes straight back to the tag; extreme byte values
	task automatic test_short_form();
		wait_idle();
		write_reg(CFG_UNUSED_LO, $urandom);
		write_reg(CFG_UNUSED_HI, $urandom);
		write_reg(CFG_BYTES_AVAILABLE, 32'd6);
		set_copy(1'b1);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Eight-byte long form near the top of a full budget, then a one-byte long
	// form; copy is switched off between tag and length to show it is sampled
	// when the header completes
	task automatic test_long_form();
		wait_idle();
		write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
		set_copy(1'b1);
		send_byte(8'h30);
		wait_idle();
		set_copy(1'b0);
		send_byte(LEN_LONG_FLAG | byte_t'(MAX_LENGTH_BYTES));
		repeat (4) send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hF0);
		send_byte(8'h02);
		send_byte(LEN_LONG_FLAG | 8'h01);
		send_byte(8'h80);
	endtask

	// Budget cleared in the middle of the content: it sticks at zero and the
	// remaining bytes still pass with the last mark on the final one
	task automatic test_budget_rewrite();
		wait_idle();
		write_reg(CFG_BYTES_AVAILABLE, 32'd5);
		set_copy(1'b1);
		send_byte(8'h04);
		send_byte(8'h03);
		send_byte(8'hA5);
		wait_idle();
		write_reg(CFG_BYTES_AVAILABLE, 32'd0);
		send_byte(8'h5A);
		send_byte(8'h3C);
	endtask

	// Long content with the sink held off while the source keeps offering
	task automatic test_backpressure();
		wait_idle();
		write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
		set_copy(1'b1);
		plan_element(1'b1, 64'd256);
		src_steady_left = 1000;
		hold_requests++;
		send_plan();
		src_steady_left = 0;
	endtask

	// Runs of well-formed elements with random content, budgets exact, with
	// slack, random or full, and copy on or off
	task automatic test_random_streams();
		int unsigned sent, n_elem, hdr_bytes, r;
		bit          copy;
		logic [31:0] budget;
		length_t     room, bound, len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			copy = ($urandom_range(0, 3) != 0);
			n_elem = $urandom_range(1, 8);
			if (copy) begin
				repeat (n_elem) begin
					r = $urandom_range(0, 99);
					if (r < 10)
						len = '0;
					else if (r < 85)
						len = length_t'($urandom_range(1, 16));
					else if (r < 97)
						len = length_t'($urandom_range(17, 127));
					else
						len = length_t'($urandom_range(128, 300));
					plan_element(1'b1, len);
				end
				case ($urandom_range(0, 3))
					0: budget = 32'(plan_bytes.size());
					1: budget = 32'(plan_bytes.size() + $urandom_range(1, 64));
					2: budget = 32'hFFFF_FFFF;
					default: begin
						budget = $urandom;
						if (budget < 32'(plan_bytes.size()))
							budget = 32'(plan_bytes.size());
					end
				endcase
			end else begin
				// headers only: keep each declared length inside what the budget
				// still holds once that header (at most ten bytes) is in
				budget = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
				room = length_t'(budget);
				repeat (n_elem) begin
					bound = room - 64'd10;
					if ($urandom_range(0, 1) != 0)
						len = length_t'($urandom_range(0, 127));
					else
						len = length_t'($urandom) % (bound + 64'd1);
					hdr_bytes = plan_bytes.size();
					plan_element(1'b0, len);
					room -= length_t'(plan_bytes.size() - hdr_bytes);
				end
			end
			sent += plan_bytes.size();
			wait_idle();
			write_reg(CFG_BYTES_AVAILABLE, budget);
			set_copy(copy);
			send_plan();
		end
	endtask

	// Drive one randomly chosen fault, then show that bytes and register
	// writes after it produce nothing
	task automatic test_error_halt();
		fault_case_t fault;
		fault = fault_case_t'($urandom_range(0, int'(fault.last())));
		wait_idle();
		set_copy(1'b1);
		case (fault)
			FAULT_EMPTY_BUDGET: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'd0);
				send_byte(byte_t'($urandom));
			end
			FAULT_TAG_IS_LAST: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'd1);
				send_byte(byte_t'($urandom));
			end
			FAULT_LEN_STARVED: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'd4);
				send_byte(byte_t'($urandom));
				wait_idle();
				write_reg(CFG_BYTES_AVAILABLE, 32'd0);
				send_byte(8'h01);
			end
			FAULT_COUNT_ZERO: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
				send_byte(byte_t'($urandom));
				send_byte(LEN_LONG_FLAG);
			end
			FAULT_COUNT_TOO_BIG: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
				send_byte(byte_t'($urandom));
				send_byte(LEN_LONG_FLAG | byte_t'($urandom_range(MAX_LENGTH_BYTES + 1, 127)));
			end
			FAULT_COUNT_OVER_BUDGET: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'd3);
				send_byte(byte_t'($urandom));
				send_byte(LEN_LONG_FLAG | 8'h02);
			end
			FAULT_LONG_STARVED: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
				send_byte(byte_t'($urandom));
				send_byte(LEN_LONG_FLAG | 8'h02);
				send_byte(8'h00);
				wait_idle();
				write_reg(CFG_BYTES_AVAILABLE, 32'd0);
				send_byte(8'h01);
			end
			FAULT_SHORT_OVERRUN: begin
				write_reg(CFG_BYTES_AVAILABLE, 32'd4);
				send_byte(byte_t'($urandom));
				send_byte(8'h7F);
			end
			default: begin
				// top length byte non-zero, so the length dwarfs any budget
				write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
				send_byte(byte_t'($urandom));
				send_byte(LEN_LONG_FLAG | byte_t'(MAX_LENGTH_BYTES));
				send_byte(byte_t'($urandom_range(1, 255)));
				repeat (MAX_LENGTH_BYTES - 1) send_byte(byte_t'($urandom));
			end
		endcase
		repeat (20) send_byte(byte_t'($urandom));
		wait_idle();
		set_copy(1'($urandom_range(0, 1)));
		write_reg(CFG_BYTES_AVAILABLE, 32'hFFFF_FFFF);
		repeat (20) send_byte(byte_t'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// Hold reset at the start, once for the whole run
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_form();
		test_long_form();
		test_budget_rewrite();
		test_backpressure();
		test_random_streams();
		test_error_halt();

		// Drain what is still due and give the last byte time to land
		wait_idle();
		if (bad_beats == 0 && tlv_beats_due.size() == 0)
			$display("der_tlv_header_parser_top: match");
		else
			$display("der_tlv_header_parser_top: mismatch");
		$finish;
	end

endmodule
